[design/ort_pkg.sv]
// shared types, codes and constants of the overlay residency tracker
package ort_pkg;

  localparam int SEC_W = 5;
  localparam int CMP_W = SEC_W + 1;
  localparam int FLD_W = 16;

  localparam logic MODE_DEFINE = 1'b0;
  localparam logic MODE_LOAD   = 1'b1;

  localparam logic [1:0] EV_LOAD   = 2'd0;
  localparam logic [1:0] EV_UNLOAD = 2'd1;
  localparam logic [1:0] EV_DONE   = 2'd2;

  typedef struct packed {
    logic             mode;
    logic [SEC_W-1:0] section;
    logic [FLD_W-1:0] first_para;
    logic [FLD_W-1:0] size_paras;
    logic [SEC_W-1:0] ancestor;
  } ort_in_t;

  typedef struct packed {
    logic [1:0]       event_res;
    logic [SEC_W-1:0] event_section;
    logic             loaded_any;
    logic             last;
  } ort_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHAIN,
    ST_CH_DAT,
    ST_SCAN,
    ST_SC_DAT,
    ST_ANC,
    ST_ANC_DAT
  } ort_state_e;

  typedef struct packed {
    logic wr_define;
    logic chain_init;
    logic rd_chain;
    logic latch_cur;
    logic chain_skip;
    logic chain_next;
    logic scan_init;
    logic scan_next;
    logic rd_scan;
    logic anc_init;
    logic rd_anc;
    logic anc_next;
    logic set_res;
    logic clr_res;
    logic emit_load;
    logic emit_unload;
    logic emit_done;
  } ort_cmd_t;

  typedef struct packed {
    logic chain_stop;
    logic cur_res;
    logic scan_end;
    logic scan_res;
    logic overlap;
    logic anc_stop;
    logic anc_res;
  } ort_stat_t;

endpackage

[design/overlay_residency_tracker.sv]
// top level of the overlay residency tracker: controller plus datapath
// define transfer: busy stays low, no result
// load transfer: each chain step reads the current entry; each section loaded adds a scan that
//   skips absent entries, tests resident ones for overlap, walks the ancestor links of the rest
//   and then closes; all table reads share one read port
// results come one per cycle at most, each a one-cycle strobe; the receiver cannot stall
// reset clears resident marks, section count and control; the table is undefined until written
module overlay_residency_tracker #(
  parameter int MAX_SECTIONS = 16,
  parameter int PARA_BITS    = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // command channel
  input  logic                      start,
  output logic                      busy,
  input  ort_pkg::ort_in_t          in_i,
  // result strobe and payload
  output logic                      out_strobe_o,
  output ort_pkg::ort_out_t         out_o,
  // section count register write channel
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [ort_pkg::SEC_W-1:0] cfg_data_i
);
  import ort_pkg::*;

  ort_cmd_t  cmd;
  ort_stat_t stat;
  logic      cfg_we;

  // count is only rewritten between requests
  assign cfg_ready_o = !busy;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  // sequencer: walks the chain, scans the table, follows ancestor links
  ort_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .mode_i (in_i.mode),
    .stat_i (stat),
    .busy   (busy),
    .cmd_o  (cmd)
  );

  // table memory with registered read, resident marks, counters, result register
  ort_dpath #(
    .MAX_SECTIONS (MAX_SECTIONS),
    .PARA_BITS    (PARA_BITS)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .cfg_we_i     (cfg_we),
    .cfg_data_i   (cfg_data_i),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_strobe_o (out_strobe_o),
    .out_o        (out_o)
  );

endmodule

[design/ort_ctrl.sv]
// sequencing state machine: chain walk, table scan and ancestor walk
module ort_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  logic              mode_i,
  input  ort_pkg::ort_stat_t stat_i,
  output logic              busy,
  output ort_pkg::ort_cmd_t cmd_o
);
  import ort_pkg::*;

  ort_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start && (mode_i == MODE_LOAD)) state_d = ST_CHAIN;
      end
      ST_CHAIN: begin
        state_d = stat_i.chain_stop ? ST_IDLE : ST_CH_DAT;
      end
      ST_CH_DAT: begin
        state_d = stat_i.cur_res ? ST_CHAIN : ST_SCAN;
      end
      ST_SCAN: begin
        priority if (stat_i.scan_end) state_d = ST_CHAIN;
        else if (!stat_i.scan_res) state_d = ST_SCAN;
        else state_d = ST_SC_DAT;
      end
      ST_SC_DAT: begin
        state_d = stat_i.overlap ? ST_SCAN : ST_ANC;
      end
      ST_ANC: begin
        priority if (stat_i.anc_stop || !stat_i.anc_res) state_d = ST_SCAN;
        else state_d = ST_ANC_DAT;
      end
      ST_ANC_DAT: begin
        state_d = ST_ANC;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o = '0;
    busy  = (state_q != ST_IDLE);
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          if (mode_i == MODE_LOAD) cmd_o.chain_init = 1'b1;
          else cmd_o.wr_define = 1'b1;
        end
      end
      ST_CHAIN: begin
        if (stat_i.chain_stop) cmd_o.emit_done = 1'b1;
        else cmd_o.rd_chain = 1'b1;
      end
      ST_CH_DAT: begin
        if (stat_i.cur_res) begin
          cmd_o.chain_skip = 1'b1;
        end else begin
          cmd_o.latch_cur = 1'b1;
          cmd_o.scan_init = 1'b1;
        end
      end
      ST_SCAN: begin
        priority if (stat_i.scan_end) begin
          cmd_o.set_res    = 1'b1;
          cmd_o.emit_load  = 1'b1;
          cmd_o.chain_next = 1'b1;
        end else if (!stat_i.scan_res) begin
          cmd_o.scan_next = 1'b1;
        end else begin
          cmd_o.rd_scan = 1'b1;
        end
      end
      ST_SC_DAT: begin
        if (stat_i.overlap) begin
          cmd_o.clr_res     = 1'b1;
          cmd_o.emit_unload = 1'b1;
          cmd_o.scan_next   = 1'b1;
        end else begin
          cmd_o.anc_init = 1'b1;
        end
      end
      ST_ANC: begin
        priority if (stat_i.anc_stop) begin
          cmd_o.scan_next = 1'b1;
        end else if (!stat_i.anc_res) begin
          cmd_o.clr_res     = 1'b1;
          cmd_o.emit_unload = 1'b1;
          cmd_o.scan_next   = 1'b1;
        end else begin
          cmd_o.rd_anc = 1'b1;
        end
      end
      ST_ANC_DAT: begin
        cmd_o.anc_next = 1'b1;
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

[design/ort_dpath.sv]
// section table, resident marks, walk counters and result register
module ort_dpath #(
  parameter int MAX_SECTIONS = 16,
  parameter int PARA_BITS    = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ort_pkg::ort_in_t         in_i,
  input  logic                     cfg_we_i,
  input  logic [ort_pkg::SEC_W-1:0] cfg_data_i,
  input  ort_pkg::ort_cmd_t        cmd_i,
  output ort_pkg::ort_stat_t       stat_o,
  output logic                     out_strobe_o,
  output ort_pkg::ort_out_t        out_o
);
  import ort_pkg::*;

  localparam int IDX_W = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
  localparam int NPAD  = 1 << IDX_W;
  localparam int CNT_W = $clog2(MAX_SECTIONS + 1);
  localparam int ENT_W = SEC_W + 2 * PARA_BITS;

  // table memory, one entry per section: {parent, size, start}
  logic [ENT_W-1:0] mem [MAX_SECTIONS];
  logic [ENT_W-1:0] rdata_q;

  logic [NPAD-1:0]      res_q;
  logic [SEC_W-1:0]     count_q;
  logic [SEC_W-1:0]     cur_q, a_q, par_q;
  logic [CNT_W-1:0]     step_q, i_q, k_q;
  logic                 any_q;
  logic [PARA_BITS-1:0] lo_q;
  logic [PARA_BITS:0]   hi_q;
  logic                 strobe_q;
  ort_out_t             out_q, out_d;

  logic [CMP_W-1:0]     cnt;
  logic                 def_ok;
  logic [IDX_W-1:0]     def_idx, cur_idx, i_idx, a_idx, rd_addr;
  logic                 rd_en;
  logic [PARA_BITS-1:0] r_start, r_size;
  logic [SEC_W-1:0]     r_par;
  logic [PARA_BITS:0]   r_end;

  assign cnt = ({1'b0, count_q} > CMP_W'(MAX_SECTIONS)) ? CMP_W'(MAX_SECTIONS)
                                                        : {1'b0, count_q};

  assign def_ok  = (in_i.section != '0) &&
                   ({1'b0, in_i.section} <= CMP_W'(MAX_SECTIONS));
  assign def_idx = IDX_W'(in_i.section - SEC_W'(1));
  assign cur_idx = IDX_W'(cur_q - SEC_W'(1));
  assign i_idx   = IDX_W'(i_q);
  assign a_idx   = IDX_W'(a_q - SEC_W'(1));

  assign r_start = rdata_q[PARA_BITS-1:0];
  assign r_size  = rdata_q[2*PARA_BITS-1:PARA_BITS];
  assign r_par   = rdata_q[ENT_W-1:2*PARA_BITS];
  assign r_end   = {1'b0, r_start} + {1'b0, r_size};

  assign rd_en = cmd_i.rd_chain | cmd_i.rd_scan | cmd_i.rd_anc;
  always_comb begin
    priority if (cmd_i.rd_chain) rd_addr = cur_idx;
    else if (cmd_i.rd_scan) rd_addr = i_idx;
    else rd_addr = a_idx;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_define && def_ok) begin
      mem[def_idx] <= {in_i.ancestor, PARA_BITS'(in_i.size_paras),
                       PARA_BITS'(in_i.first_para)};
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  // status
  assign stat_o.chain_stop = (cur_q == '0) || ({1'b0, cur_q} > cnt) ||
                             (step_q == CNT_W'(MAX_SECTIONS));
  assign stat_o.cur_res    = res_q[cur_idx];
  assign stat_o.scan_end   = (CMP_W'(i_q) == cnt);
  assign stat_o.scan_res   = res_q[i_idx];
  assign stat_o.overlap    = ({1'b0, r_start} < hi_q) && (r_end > {1'b0, lo_q});
  assign stat_o.anc_stop   = (a_q == '0) || ({1'b0, a_q} > cnt) ||
                             (k_q == CNT_W'(MAX_SECTIONS));
  assign stat_o.anc_res    = res_q[a_idx];

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q    <= '0;
      count_q  <= '0;
      strobe_q <= 1'b0;
    end else begin
      if (cfg_we_i) count_q <= cfg_data_i;
      if (cmd_i.wr_define && def_ok) res_q[def_idx] <= 1'b0;
      if (cmd_i.set_res) res_q[cur_idx] <= 1'b1;
      if (cmd_i.clr_res) res_q[i_idx] <= 1'b0;
      strobe_q <= cmd_i.emit_load | cmd_i.emit_unload | cmd_i.emit_done;
    end
  end

  // next result payload
  always_comb begin
    out_d = '0;
    if (cmd_i.emit_load) begin
      out_d.event_res     = EV_LOAD;
      out_d.event_section = cur_q;
    end
    if (cmd_i.emit_unload) begin
      out_d.event_res     = EV_UNLOAD;
      out_d.event_section = SEC_W'(i_q) + SEC_W'(1);
    end
    if (cmd_i.emit_done) begin
      out_d.event_res  = EV_DONE;
      out_d.loaded_any = any_q;
      out_d.last       = 1'b1;
    end
  end

  // walk registers and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.chain_init) begin
      cur_q  <= in_i.section;
      step_q <= '0;
      any_q  <= 1'b0;
    end
    if (cmd_i.chain_skip) begin
      cur_q  <= r_par;
      step_q <= step_q + CNT_W'(1);
    end
    if (cmd_i.chain_next) begin
      cur_q  <= par_q;
      step_q <= step_q + CNT_W'(1);
    end
    if (cmd_i.latch_cur) begin
      lo_q  <= r_start;
      hi_q  <= r_end;
      par_q <= r_par;
    end
    if (cmd_i.scan_init) begin
      i_q   <= '0;
      any_q <= 1'b1;
    end
    if (cmd_i.scan_next) i_q <= i_q + CNT_W'(1);
    if (cmd_i.anc_init) begin
      a_q <= r_par;
      k_q <= '0;
    end
    if (cmd_i.anc_next) begin
      a_q <= r_par;
      k_q <= k_q + CNT_W'(1);
    end
    out_q <= out_d;
  end

  assign out_strobe_o = strobe_q;
  assign out_o        = out_q;

endmodule
